/* rtl/core/fla_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Free list slot allocator package
// Shared constants, operation and status codes, and control structures.
// ----------------------------------------------------------------------------
package fla_pkg;

    localparam int SLOT_COUNT           = 256;
    localparam int SLOT_BITS            = $clog2(SLOT_COUNT);
    localparam int COUNT_BITS           = SLOT_BITS + 1;
    localparam int DEFAULT_HANDLE_BITS  = 32;
    localparam int MODE_BITS            = 2;
    localparam int STATUS_BITS          = 2;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_CREATE  = 2'd0,
        MODE_DESTROY = 2'd1,
        MODE_LOOKUP  = 2'd2,
        MODE_UNUSED  = 2'd3
    } mode_t;

    localparam logic [STATUS_BITS-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_BAD  = 2'd2;

    // Control from the sequencer to the slot table.
    typedef struct packed {
        logic                 rd_en;
        logic [SLOT_BITS-1:0] rd_addr;
        logic                 wr_en;
        logic                 clr_en;
        logic [SLOT_BITS-1:0] wr_addr;
    } slot_ctrl_t;

    // Control from the sequencer to the free queue.
    typedef struct packed {
        logic                 rd_en;
        logic                 pop;
        logic                 push;
        logic [SLOT_BITS-1:0] push_slot;
    } queue_ctrl_t;

    // Status from the free queue back to the sequencer.
    typedef struct packed {
        logic                 empty;
        logic [SLOT_BITS-1:0] head_slot;
    } queue_stat_t;

endpackage : fla_pkg
`default_nettype wire

/* rtl/core/fla_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Free list slot allocator channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface fla_req_if #(
    parameter int HANDLE_BITS = fla_pkg::DEFAULT_HANDLE_BITS
) ();
    logic                           valid;
    logic                           ready;
    logic [fla_pkg::MODE_BITS-1:0]  mode;
    logic [fla_pkg::SLOT_BITS-1:0]  slot_index;
    logic [HANDLE_BITS-1:0]         handle;

    modport source (output valid, output mode, output slot_index, output handle,
                    input ready);
    modport sink   (input valid, input mode, input slot_index, input handle,
                    output ready);
endinterface : fla_req_if

interface fla_rsp_if #(
    parameter int HANDLE_BITS = fla_pkg::DEFAULT_HANDLE_BITS
) ();
    logic                            valid;
    logic                            ready;
    logic [fla_pkg::STATUS_BITS-1:0] status;
    logic [fla_pkg::SLOT_BITS-1:0]   result_index;
    logic [HANDLE_BITS-1:0]          stored_handle;

    modport source (output valid, output status, output result_index,
                    output stored_handle, input ready);
    modport sink   (input valid, input status, input result_index,
                    input stored_handle, output ready);
endinterface : fla_rsp_if
`default_nettype wire

/* rtl/core/free_list_slot_allocator.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Free list slot allocator
// Slot table with create, destroy and lookup requests and a FIFO free list.
// ----------------------------------------------------------------------------
// Usage: requests arrive on req (mode, slot_index, handle) and each produces
// exactly one response on rsp (status, result_index, stored_handle).
// The edge that accepts a request in ST_IDLE reads the payload memory,
// the active flag and the head of the free queue; in ST_EXEC an edge with
// the response register free resolves it, writes the memories back and loads the response register.
// Request ready is high only in ST_IDLE, so the block takes no new request
// until it has resolved the previous one.
// The response is registered, so a request may be accepted while the
// previous response still waits. If the receiver stalls, the pending
// request holds in the resolve stage until the response register frees.
// After reset all slots are inactive, the free queue is empty and no slot
// has been handed out; the block accepts requests at once.
// ----------------------------------------------------------------------------
module free_list_slot_allocator #(
    parameter int HANDLE_BITS = fla_pkg::DEFAULT_HANDLE_BITS
) (
    input  wire logic clk,
    input  wire logic rst_n,
    fla_req_if.sink   req,
    fla_rsp_if.source rsp
);
    import fla_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;
    logic [MODE_BITS-1:0]    mode_reg;
    logic [SLOT_BITS-1:0]    index_reg;
    logic [HANDLE_BITS-1:0]  handle_reg;
    logic [COUNT_BITS-1:0]   high_water_reg;
    logic [COUNT_BITS-1:0]   high_water_next;

    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [STATUS_BITS-1:0]  out_status_reg;
    logic [STATUS_BITS-1:0]  out_status_next;
    logic [SLOT_BITS-1:0]    out_index_reg;
    logic [SLOT_BITS-1:0]    out_index_next;
    logic [HANDLE_BITS-1:0]  out_handle_reg;
    logic [HANDLE_BITS-1:0]  out_handle_next;

    slot_ctrl_t              slot_ctrl;
    queue_ctrl_t             queue_ctrl;
    queue_stat_t             queue_stat;
    logic [HANDLE_BITS-1:0]  slot_rd_data;
    logic                    slot_rd_active;

    logic                    accept;
    logic                    resolve;
    logic                    slot_valid;
    logic [SLOT_BITS-1:0]    fresh_slot;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    // The result may be written when the response register is empty or drains.
    assign resolve   = (state_reg == ST_EXEC) && (!out_valid_reg || rsp.ready);

    assign slot_valid = ({1'b0, index_reg} < high_water_reg) && slot_rd_active;
    assign fresh_slot = high_water_reg[SLOT_BITS-1:0];

    always_comb
    begin
        state_next      = state_reg;
        high_water_next = high_water_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_index_next  = out_index_reg;
        out_handle_next = out_handle_reg;

        slot_ctrl.rd_en    = accept;
        slot_ctrl.rd_addr  = req.slot_index;
        slot_ctrl.wr_en    = 1'b0;
        slot_ctrl.clr_en   = 1'b0;
        slot_ctrl.wr_addr  = index_reg;

        queue_ctrl.rd_en     = accept;
        queue_ctrl.pop       = 1'b0;
        queue_ctrl.push      = 1'b0;
        queue_ctrl.push_slot = index_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (resolve)
                begin
                    state_next      = ST_IDLE;
                    out_valid_next  = 1'b1;
                    out_status_next = STATUS_BAD;
                    out_index_next  = '0;
                    out_handle_next = '0;
                    unique case (mode_t'(mode_reg))
                        MODE_CREATE:
                        begin
                            if (!queue_stat.empty)
                            begin
                                queue_ctrl.pop    = 1'b1;
                                slot_ctrl.wr_en   = 1'b1;
                                slot_ctrl.wr_addr = queue_stat.head_slot;
                                out_status_next   = STATUS_OK;
                                out_index_next    = queue_stat.head_slot;
                            end
                            else if (high_water_reg != COUNT_BITS'(SLOT_COUNT))
                            begin
                                high_water_next   = high_water_reg + 1'b1;
                                slot_ctrl.wr_en   = 1'b1;
                                slot_ctrl.wr_addr = fresh_slot;
                                out_status_next   = STATUS_OK;
                                out_index_next    = fresh_slot;
                            end
                            else
                            begin
                                out_status_next = STATUS_FULL;
                            end
                        end
                        MODE_DESTROY:
                        begin
                            if (slot_valid)
                            begin
                                slot_ctrl.clr_en = 1'b1;
                                queue_ctrl.push  = 1'b1;
                                out_status_next  = STATUS_OK;
                            end
                        end
                        MODE_LOOKUP:
                        begin
                            if (slot_valid)
                            begin
                                out_status_next = STATUS_OK;
                                out_handle_next = slot_rd_data;
                            end
                        end
                        default:
                        begin
                            out_status_next = STATUS_BAD;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg   <= req.mode;
            index_reg  <= req.slot_index;
            handle_reg <= req.handle;
        end
        out_status_reg <= out_status_next;
        out_index_reg  <= out_index_next;
        out_handle_reg <= out_handle_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            high_water_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            high_water_reg <= high_water_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    fla_slot_table #(
        .HANDLE_BITS (HANDLE_BITS)
    ) u_slot_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (slot_ctrl),
        .wr_data   (handle_reg),
        .rd_data   (slot_rd_data),
        .rd_active (slot_rd_active)
    );

    fla_free_queue u_free_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (queue_ctrl),
        .stat  (queue_stat)
    );

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.result_index  = out_index_reg;
    assign rsp.stored_handle = out_handle_reg;

endmodule : free_list_slot_allocator
`default_nettype wire

/* rtl/core/fla_slot_table.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Slot table
// Payload memory with a registered read port and per-slot active flags.
// ----------------------------------------------------------------------------
module fla_slot_table #(
    parameter int HANDLE_BITS = fla_pkg::DEFAULT_HANDLE_BITS
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire fla_pkg::slot_ctrl_t    ctrl,
    input  wire logic [HANDLE_BITS-1:0] wr_data,
    output logic [HANDLE_BITS-1:0]      rd_data,
    output logic                        rd_active
);
    import fla_pkg::*;

    logic [HANDLE_BITS-1:0] payload_mem [SLOT_COUNT];
    logic [HANDLE_BITS-1:0] rd_data_reg;
    logic [SLOT_COUNT-1:0]  active_reg;
    logic                   rd_active_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            payload_mem[ctrl.wr_addr] <= wr_data;
        end
        if (ctrl.rd_en)
        begin
            rd_data_reg <= payload_mem[ctrl.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= '0;
            rd_active_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.wr_en)
            begin
                active_reg[ctrl.wr_addr] <= 1'b1;
            end
            else if (ctrl.clr_en)
            begin
                active_reg[ctrl.wr_addr] <= 1'b0;
            end
            if (ctrl.rd_en)
            begin
                rd_active_reg <= active_reg[ctrl.rd_addr];
            end
        end
    end

    assign rd_data   = rd_data_reg;
    assign rd_active = rd_active_reg;

endmodule : fla_slot_table
`default_nettype wire

/* rtl/core/fla_free_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Free queue
// Circular buffer of released slot indices, oldest first.
// ----------------------------------------------------------------------------
module fla_free_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire fla_pkg::queue_ctrl_t ctrl,
    output fla_pkg::queue_stat_t      stat
);
    import fla_pkg::*;

    logic [SLOT_BITS-1:0]  queue_mem [SLOT_COUNT];
    logic [SLOT_BITS-1:0]  head_data_reg;
    logic [SLOT_BITS-1:0]  head_reg;
    logic [SLOT_BITS-1:0]  head_next;
    logic [SLOT_BITS-1:0]  tail_reg;
    logic [SLOT_BITS-1:0]  tail_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic                  push_ok;

    // The pointers span exactly the queue depth, so they wrap on overflow.
    assign push_ok = ctrl.push && (count_reg != COUNT_BITS'(SLOT_COUNT));

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (ctrl.pop)
        begin
            head_next  = head_reg + 1'b1;
            count_next = count_next - 1'b1;
        end
        if (push_ok)
        begin
            tail_next  = tail_reg + 1'b1;
            count_next = count_next + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            queue_mem[tail_reg] <= ctrl.push_slot;
        end
        if (ctrl.rd_en)
        begin
            head_data_reg <= queue_mem[head_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    assign stat.empty     = (count_reg == '0);
    assign stat.head_slot = head_data_reg;

endmodule : fla_free_queue
`default_nettype wire

/* sim/free_list_slot_allocator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Free list slot allocator testbench
// Drives create, destroy and lookup requests through the request channel and
// checks every response against a behavioural slot table with a FIFO free
// list. It runs directed corner cases, a fill to the full table, a long
// response hold-off and random traffic under several idling patterns.
// ----------------------------------------------------------------------------
module free_list_slot_allocator_tb;

    import fla_pkg::*;

    localparam int HANDLE_BITS = DEFAULT_HANDLE_BITS;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS_PER_PHASE = 365;

    typedef struct {
        logic [STATUS_BITS-1:0] status;
        logic [SLOT_BITS-1:0]   index;
        logic [HANDLE_BITS-1:0] handle;
    } response_t;

    logic clk;
    logic rst_n;

    fla_req_if #(.HANDLE_BITS(HANDLE_BITS)) req ();
    fla_rsp_if #(.HANDLE_BITS(HANDLE_BITS)) rsp ();

    free_list_slot_allocator #(
        .HANDLE_BITS (HANDLE_BITS)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Behavioural copy of the slot table.
    logic [HANDLE_BITS-1:0] table_payload [SLOT_COUNT];
    bit                     table_active [SLOT_COUNT];
    int                     table_high_water;
    logic [SLOT_BITS-1:0]   free_slots [$];

    response_t outstanding_responses [$];
    int        mismatch_count;
    int        cycle_count;
    int        send_idle_pct;
    int        recv_stall_pct;
    int        hold_off_request;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Response side: random stalls, plus a long hold-off when one is asked for.
    initial
    begin : response_receiver
        int hold_left;
        hold_left = 0;
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_request > 0)
            begin
                hold_left = hold_off_request;
                hold_off_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp.ready <= 1'b0;
            end
            else
            begin
                rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        $display("mismatch at cycle %0d: %s expected %0h got %0h",
                 cycle_count, what, want, got);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin : check_responses
        response_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (outstanding_responses.size() == 0)
            begin
                report_mismatch("response with nothing outstanding, status", 0, rsp.status);
            end
            else
            begin
                want = outstanding_responses.pop_front();
                if (rsp.status !== want.status)
                    report_mismatch("status", want.status, rsp.status);
                if (rsp.result_index !== want.index)
                    report_mismatch("result_index", want.index, rsp.result_index);
                if (rsp.stored_handle !== want.handle)
                    report_mismatch("stored_handle", want.handle, rsp.stored_handle);
            end
        end
    end

    // Applies one accepted request to the table copy and returns its response.
    function automatic response_t apply_table_request(input mode_t op,
                                                      input logic [SLOT_BITS-1:0] idx,
                                                      input logic [HANDLE_BITS-1:0] h);
        response_t r;
        int        slot;
        bit        usable;
        r.status = STATUS_BAD;
        r.index  = '0;
        r.handle = '0;
        usable = (int'(idx) < table_high_water) && table_active[idx];
        case (op)
            MODE_CREATE:
            begin
                slot = -1;
                if (free_slots.size() != 0)
                begin
                    slot = free_slots.pop_front();
                end
                else if (table_high_water < SLOT_COUNT)
                begin
                    slot = table_high_water;
                    table_high_water = table_high_water + 1;
                end
                if (slot < 0)
                begin
                    r.status = STATUS_FULL;
                end
                else
                begin
                    table_payload[slot] = h;
                    table_active[slot]  = 1'b1;
                    r.status = STATUS_OK;
                    r.index  = SLOT_BITS'(slot);
                end
            end
            MODE_DESTROY:
            begin
                if (usable)
                begin
                    table_active[idx]  = 1'b0;
                    table_payload[idx] = '0;
                    free_slots.insert(free_slots.size(), idx);
                    r.status = STATUS_OK;
                end
            end
            MODE_LOOKUP:
            begin
                if (usable)
                begin
                    r.status = STATUS_OK;
                    r.handle = table_payload[idx];
                end
            end
            default:
            begin
                r.status = STATUS_BAD;
            end
        endcase
        return r;
    endfunction

    function automatic int pick_active_slot();
        int live;
        int pick;
        live = 0;
        for (int s = 0; s < SLOT_COUNT; s++)
            if (table_active[s])
                live++;
        if (live == 0)
            return -1;
        pick = $urandom_range(live - 1);
        for (int s = 0; s < SLOT_COUNT; s++)
        begin
            if (table_active[s])
            begin
                if (pick == 0)
                    return s;
                pick--;
            end
        end
        return -1;
    endfunction

    // Offers one request, with random idle cycles first, and records the
    // expected response once the request is taken.
    task automatic send_request(input mode_t op, input logic [SLOT_BITS-1:0] idx,
                                input logic [HANDLE_BITS-1:0] h);
        response_t expected;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid      <= 1'b1;
        req.mode       <= op;
        req.slot_index <= idx;
        req.handle     <= h;
        do
            @(posedge clk);
        while (!req.ready);
        expected = apply_table_request(op, idx, h);
        outstanding_responses.insert(outstanding_responses.size(), expected);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        req.valid <= 1'b0;
        while (outstanding_responses.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        send_request(MODE_LOOKUP, 8'd0, '0);
        send_request(MODE_DESTROY, 8'd0, '0);
        send_request(MODE_DESTROY, 8'd255, '1);
        send_request(MODE_UNUSED, 8'd255, '1);
        send_request(MODE_CREATE, 8'd0, '0);
        send_request(MODE_CREATE, 8'd255, '1);
        send_request(MODE_CREATE, 8'd7, 32'hA5A5_5A5A);
        send_request(MODE_LOOKUP, 8'd0, '1);
        send_request(MODE_LOOKUP, 8'd1, '0);
        send_request(MODE_LOOKUP, 8'd3, '0);
        send_request(MODE_DESTROY, 8'd1, '0);
        // A second destroy of the same slot must not queue it twice.
        send_request(MODE_DESTROY, 8'd1, '0);
        send_request(MODE_LOOKUP, 8'd1, '0);
        send_request(MODE_DESTROY, 8'd0, '0);
        send_request(MODE_CREATE, 8'd0, 32'h0000_0001);
        send_request(MODE_CREATE, 8'd0, 32'h8000_0000);
        send_request(MODE_CREATE, 8'd0, 32'h1234_5678);
        send_request(MODE_LOOKUP, 8'd255, '0);
        send_request(MODE_UNUSED, 8'd0, '0);
        wait_drained();
    endtask

    task automatic test_table_full();
        while (table_high_water < SLOT_COUNT || free_slots.size() != 0)
            send_request(MODE_CREATE, 8'($urandom), $urandom);
        send_request(MODE_CREATE, 8'd0, '1);
        send_request(MODE_CREATE, 8'd255, '0);
        send_request(MODE_LOOKUP, 8'd255, '0);
        send_request(MODE_DESTROY, 8'd255, '0);
        send_request(MODE_DESTROY, 8'd17, '0);
        send_request(MODE_CREATE, 8'd0, $urandom);
        send_request(MODE_CREATE, 8'd0, $urandom);
        send_request(MODE_CREATE, 8'd0, $urandom);
        wait_drained();
    endtask

    // The receiver holds off long enough for the block to back up and drop
    // its request ready while requests keep being offered.
    task automatic test_response_hold_off();
        int slot;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_request = 90;
        for (int n = 0; n < 12; n++)
        begin
            slot = pick_active_slot();
            if (n % 2 == 0 && slot >= 0)
                send_request(MODE_LOOKUP, SLOT_BITS'(slot), $urandom);
            else
                send_request(MODE_DESTROY, 8'($urandom), $urandom);
        end
        wait_drained();
    endtask

    task automatic test_random_traffic(input int count, input int idle_pct,
                                       input int stall_pct);
        mode_t                op;
        int                   slot;
        int                   create_pct;
        int                   r;
        logic [SLOT_BITS-1:0] idx;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        create_pct = 50;
        for (int n = 0; n < count; n++)
        begin
            // Swing between filling and emptying the table so that both the
            // full table and the recycled free list are exercised.
            if (n % 64 == 0)
            begin
                case ($urandom_range(2))
                    0: create_pct = 15;
                    1: create_pct = 50;
                    default: create_pct = 85;
                endcase
            end
            r = $urandom_range(99);
            if (r < create_pct)
            begin
                op = MODE_CREATE;
            end
            else
            begin
                r = $urandom_range(99);
                if (r < 5)
                    op = MODE_UNUSED;
                else if (r < 55)
                    op = MODE_DESTROY;
                else
                    op = MODE_LOOKUP;
            end
            r = $urandom_range(99);
            slot = pick_active_slot();
            if (r < 75 && slot >= 0)
                idx = SLOT_BITS'(slot);
            else if (r < 88 && table_high_water > 0)
                idx = SLOT_BITS'($urandom_range(table_high_water - 1));
            else
                idx = SLOT_BITS'($urandom_range(SLOT_COUNT - 1));
            send_request(op, idx, $urandom);
        end
        wait_drained();
    endtask

    initial
    begin
        mismatch_count   = 0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        hold_off_request = 0;
        table_high_water = 0;
        for (int s = 0; s < SLOT_COUNT; s++)
        begin
            table_active[s]  = 1'b0;
            table_payload[s] = '0;
        end
        rst_n          = 1'b0;
        req.valid      = 1'b0;
        req.mode       = MODE_CREATE;
        req.slot_index = '0;
        req.handle     = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_table_full();
        test_response_hold_off();
        test_random_traffic(RANDOM_ITEMS_PER_PHASE, 0, 0);
        test_random_traffic(RANDOM_ITEMS_PER_PHASE, 68, 0);
        test_random_traffic(RANDOM_ITEMS_PER_PHASE, 0, 68);
        test_random_traffic(RANDOM_ITEMS_PER_PHASE, 31, 31);

        wait_drained();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
